>>> design/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define UPR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ultrasonic ping ranger assertion failed");

// Condition must never be true at a rising clock edge outside reset.
`define UPR_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("ultrasonic ping ranger forbidden condition seen");

`endif

>>> design/upr_pkg.sv
// Package of the ultrasonic ping ranger: widths, constants and types.
// Used by every file of the block but assert_macros.svh; depends on nothing.
package upr_pkg;

  localparam int unsigned TimerW   = 16;
  localparam int unsigned DistW    = 17;
  localparam int unsigned StopW    = 8;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned MulW     = 19;
  localparam int unsigned ProdW    = TimerW + MulW;

  localparam logic [TimerW-1:0]   TriggerTicks   = 16'd7;
  localparam logic [TimerW-1:0]   EchoOffset     = 16'd40;
  localparam logic [TimerW-1:0]   EchoTimeoutRst = 16'd40000;
  localparam logic [TimerW-1:0]   TimerMax       = 16'hFFFF;
  localparam logic [MulW-1:0]     ScaleMul       = 19'd287725;
  localparam logic [MulW-1:0]     LimitQ8        = 19'd128000;
  localparam logic [DistW-1:0]    FarQ8          = 17'd128256;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_HIGH  = 6'b000010,
    PH_LOW   = 6'b000100,
    PH_ARM   = 6'b001000,
    PH_WAIT1 = 6'b010000,
    PH_WAIT2 = 6'b100000
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STOP_DISTANCE = 8'd0,
    CFG_ECHO_TIMEOUT  = 8'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             clear;
  } range_t;

  typedef struct packed {
    logic             pin_drive_enable;
    logic             pin_drive_level;
    logic             busy_res;
    logic             done_res;
    logic [DistW-1:0] distance_q8;
    logic             path_clear;
  } res_t;

endpackage

>>> design/upr_if.sv
// Channel interfaces of the ultrasonic ping ranger: tick input, result, config write.
// Depends on upr_pkg for the field widths.
interface upr_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;

  modport source (output valid, output start_req, output echo_level, input ready);
  modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

interface upr_out_if import upr_pkg::*;;
  logic             valid;
  logic             ready;
  logic             pin_drive_enable;
  logic             pin_drive_level;
  logic             busy_res;
  logic             done_res;
  logic [DistW-1:0] distance_q8;
  logic             path_clear;

  modport source (output valid, output pin_drive_enable, output pin_drive_level,
                  output busy_res, output done_res, output distance_q8,
                  output path_clear, input ready);
  modport sink   (input valid, input pin_drive_enable, input pin_drive_level,
                  input busy_res, input done_res, input distance_q8,
                  input path_clear, output ready);
endinterface

interface upr_cfg_if import upr_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/upr_range.sv
// Converts an echo tick count into a distance in 1/256 cm and a clearance flag.
// Depends on upr_pkg for constants and the range_t type.
module upr_range import upr_pkg::*; (
  input  logic [TimerW-1:0] elapsed_i,
  input  logic [StopW-1:0]  stop_distance_i,
  output range_t            range_o
);

  logic [TimerW-1:0] diff;
  logic [ProdW-1:0]  prod;
  logic [MulW-1:0]   scaled;
  logic [DistW-1:0]  range_dist;

  assign diff   = elapsed_i - EchoOffset;
  assign prod   = ProdW'(diff) * ProdW'(ScaleMul);
  assign scaled = prod[ProdW-1:16];

  always_comb begin
    if (elapsed_i < EchoOffset || scaled >= LimitQ8) begin
      range_dist = FarQ8;
    end else begin
      range_dist = scaled[DistW-1:0];
    end
  end

  assign range_o.distance = range_dist;
  assign range_o.clear    = range_dist > DistW'({stop_distance_i, 8'd0});

endmodule

>>> design/ultrasonic_ping_ranger.sv
// Top level of the ultrasonic ping ranger: trigger/echo sequencer and result buffer.
// Depends on upr_pkg, the channel interfaces in upr_if.sv and upr_range.
//
//   channel  direction  word
//   in_i     sink       start_req, echo_level (one microsecond tick)
//   out_o    source     pin drive, busy, done, distance_q8, path_clear
//   cfg_i    sink       register index, write data
//
// Every tick word yields one result word; a word can be accepted in every cycle
// while the skid register is empty. The sequencer update and the distance
// multiply sit between the state registers and the result register. An output
// register and a skid register let one more tick in while a result is stalled.
// Reset puts the sequencer in idle and restores the register defaults.
module ultrasonic_ping_ranger import upr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  upr_in_if.sink    in_i,
  upr_out_if.source out_o,
  upr_cfg_if.sink   cfg_i
);

  logic [StopW-1:0]  stop_distance_q;
  logic [TimerW-1:0] echo_timeout_q;

  phase_e            phase_q, phase_d;
  logic [TimerW-1:0] timer_q, timer_d;
  logic              ref_level_q, ref_level_d;
  logic [DistW-1:0]  last_dist_q, last_dist_d;
  logic              last_clear_q, last_clear_d;
  logic              done;
  logic [TimerW-1:0] timer_inc;
  logic              edge_seen;
  range_t            range;
  res_t              res;

  res_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic in_acc;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_distance_q <= '0;
      echo_timeout_q  <= EchoTimeoutRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_STOP_DISTANCE: stop_distance_q <= cfg_i.data[StopW-1:0];
        CFG_ECHO_TIMEOUT:  echo_timeout_q  <= cfg_i.data[TimerW-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = !skid_valid_q;
  assign in_acc     = in_i.valid && in_i.ready;

  assign timer_inc = (timer_q == TimerMax) ? timer_q : timer_q + 16'd1;
  assign edge_seen = (in_i.echo_level != ref_level_q) || (timer_inc >= echo_timeout_q);

  upr_range u_range (
    .elapsed_i       (timer_inc),
    .stop_distance_i (stop_distance_q),
    .range_o         (range)
  );

  always_comb begin
    phase_d      = phase_q;
    timer_d      = timer_q;
    ref_level_d  = ref_level_q;
    last_dist_d  = last_dist_q;
    last_clear_d = last_clear_q;
    done         = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (in_i.start_req) begin
          phase_d = PH_HIGH;
          timer_d = '0;
        end
      end
      PH_HIGH: begin
        timer_d = timer_inc;
        if (timer_inc >= TriggerTicks) begin
          phase_d = PH_LOW;
        end
      end
      PH_LOW: begin
        phase_d = PH_ARM;
      end
      PH_ARM: begin
        ref_level_d = in_i.echo_level;
        timer_d     = '0;
        phase_d     = PH_WAIT1;
      end
      PH_WAIT1: begin
        timer_d = timer_inc;
        if (edge_seen) begin
          ref_level_d = in_i.echo_level;
          timer_d     = '0;
          phase_d     = PH_WAIT2;
        end
      end
      PH_WAIT2: begin
        timer_d = timer_inc;
        if (edge_seen) begin
          last_dist_d  = range.distance;
          last_clear_d = range.clear;
          done         = 1'b1;
          phase_d      = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  assign res.pin_drive_enable = (phase_d == PH_HIGH) || (phase_d == PH_LOW);
  assign res.pin_drive_level  = (phase_d == PH_HIGH);
  assign res.busy_res         = (phase_d != PH_IDLE);
  assign res.done_res         = done;
  assign res.distance_q8      = last_dist_d;
  assign res.path_clear       = last_clear_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      timer_q      <= '0;
      ref_level_q  <= 1'b0;
      last_dist_q  <= '0;
      last_clear_q <= 1'b0;
    end else if (in_acc) begin
      phase_q      <= phase_d;
      timer_q      <= timer_d;
      ref_level_q  <= ref_level_d;
      last_dist_q  <= last_dist_d;
      last_clear_q <= last_clear_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q  <= skid_valid_q || in_acc;
      skid_valid_q <= 1'b0;
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_o.ready) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.pin_drive_enable = out_q.pin_drive_enable;
  assign out_o.pin_drive_level  = out_q.pin_drive_level;
  assign out_o.busy_res         = out_q.busy_res;
  assign out_o.done_res         = out_q.done_res;
  assign out_o.distance_q8      = out_q.distance_q8;
  assign out_o.path_clear       = out_q.path_clear;

endmodule

>>> design/upr_checker.sv
// Port-level checker of the ultrasonic ping ranger and its bind to the top level.
// Depends on upr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module upr_checker import upr_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             pin_drive_enable_i,
  input logic             pin_drive_level_i,
  input logic [DistW-1:0] distance_q8_i
);

  `UPR_ASSERT(a_accept_gives_word, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> out_valid_i)
  `UPR_ASSERT(a_backpressure_only_when_full, clk_i, rst_ni, !in_ready_i |-> out_valid_i)
  `UPR_ASSERT_NEVER(a_word_in_range, clk_i, rst_ni,
                    out_valid_i && ((distance_q8_i > FarQ8) ||
                                    (pin_drive_level_i && !pin_drive_enable_i)))
  `UPR_ASSERT(a_stall_holds, clk_i, rst_ni,
              (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(distance_q8_i)))

endmodule

bind ultrasonic_ping_ranger upr_checker u_upr_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .pin_drive_enable_i (out_o.pin_drive_enable),
  .pin_drive_level_i  (out_o.pin_drive_level),
  .distance_q8_i      (out_o.distance_q8)
);

>>> tb/tb_ultrasonic_ping_ranger.sv
// Self-checking testbench of the ultrasonic ping ranger: drives tick words, checks every result.
// Depends on upr_pkg and the channel interfaces in upr_if.sv; holds its own timing and range model.
module tb_ultrasonic_ping_ranger import upr_pkg::*;;

  localparam int unsigned PING_HIGH_TICKS = 7;
  localparam logic [63:0] ECHO_DEAD_TICKS = 64'd40;
  localparam logic [63:0] Q8_PER_TICK     = 64'd287725;
  localparam logic [63:0] RANGE_LIMIT_Q8  = 64'd128000;
  localparam logic [16:0] FAR_RANGE_Q8    = 17'd128256;
  localparam int          PRESSURE_AT     = 150;
  localparam int          PRESSURE_CYCLES = 300;
  localparam int          REPORT_LINES    = 40;

  typedef struct packed {
    logic start;
    logic level;
  } tick_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                tick_valid = 1'b0;
  logic                tick_start = 1'b0;
  logic                tick_level = 1'b0;
  logic                range_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  upr_in_if  tick_if ();
  upr_out_if range_if ();
  upr_cfg_if cfg_if ();

  assign tick_if.valid      = tick_valid;
  assign tick_if.start_req  = tick_start;
  assign tick_if.echo_level = tick_level;
  assign range_if.ready     = range_ready;
  assign cfg_if.valid       = cfg_valid;
  assign cfg_if.index       = cfg_index;
  assign cfg_if.data        = cfg_data;

  ultrasonic_ping_ranger i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_if),
    .out_o  (range_if),
    .cfg_i  (cfg_if)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Ranger model state and its copy of the registers.
  phase_e      pred_phase = PH_IDLE;
  logic [15:0] pred_timer = '0;
  logic        pred_ref = 1'b0;
  logic [16:0] last_q8 = '0;
  logic        last_clear = 1'b0;
  logic [7:0]  stop_cm = 8'd0;
  logic [15:0] echo_limit = 16'd40000;

  tick_t tick_q[$];
  res_t  range_exp_q[$];
  tick_t tick_next;
  int    tick_gap = 0;
  int    range_hold = 0;
  int    n_res = 0;
  int    mismatches = 0;
  int    ticks_queued = 0;
  bit    calm = 1'b0;

  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(0, 10));
  endfunction

  function automatic void count_tick();
    if (pred_timer != 16'hFFFF) pred_timer = pred_timer + 16'd1;
  endfunction

  function automatic logic [16:0] echo_to_q8(logic [15:0] elapsed);
    logic [63:0] scaled;
    if ({48'd0, elapsed} < ECHO_DEAD_TICKS) return FAR_RANGE_Q8;
    scaled = (({48'd0, elapsed} - ECHO_DEAD_TICKS) * Q8_PER_TICK) >> 16;
    if (scaled >= RANGE_LIMIT_Q8) return FAR_RANGE_Q8;
    return scaled[16:0];
  endfunction

  function automatic res_t ranger_step(logic start, logic level);
    res_t r;
    logic done;
    done = 1'b0;
    case (pred_phase)
      PH_IDLE: begin
        if (start) begin
          pred_phase = PH_HIGH;
          pred_timer = '0;
        end
      end
      PH_HIGH: begin
        count_tick();
        if (pred_timer >= 16'(PING_HIGH_TICKS)) pred_phase = PH_LOW;
      end
      PH_LOW: pred_phase = PH_ARM;
      PH_ARM: begin
        pred_ref = level;
        pred_timer = '0;
        pred_phase = PH_WAIT1;
      end
      PH_WAIT1: begin
        count_tick();
        if (level != pred_ref || pred_timer >= echo_limit) begin
          pred_ref = level;
          pred_timer = '0;
          pred_phase = PH_WAIT2;
        end
      end
      PH_WAIT2: begin
        count_tick();
        if (level != pred_ref || pred_timer >= echo_limit) begin
          last_q8 = echo_to_q8(pred_timer);
          last_clear = last_q8 > {1'b0, stop_cm, 8'd0};
          done = 1'b1;
          pred_phase = PH_IDLE;
        end
      end
      default: pred_phase = PH_IDLE;
    endcase
    r.pin_drive_enable = (pred_phase == PH_HIGH) || (pred_phase == PH_LOW);
    r.pin_drive_level  = (pred_phase == PH_HIGH);
    r.busy_res         = (pred_phase != PH_IDLE);
    r.done_res         = done;
    r.distance_q8      = last_q8;
    r.path_clear       = last_clear;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < REPORT_LINES) $display("MISMATCH %s", msg);
    mismatches++;
  endtask

  // Tick driver: each accepted word is run through the model at once.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (tick_valid && tick_if.ready) range_exp_q.push_back(ranger_step(tick_start, tick_level));
      if (!tick_valid || tick_if.ready) begin
        if (tick_valid) tick_gap = draw_gap();
        if (tick_gap != 0 || tick_q.size() == 0) begin
          tick_valid <= 1'b0;
          if (tick_gap != 0) tick_gap--;
        end else begin
          tick_next = tick_q.pop_front();
          tick_valid <= 1'b1;
          tick_start <= tick_next.start;
          tick_level <= tick_next.level;
        end
      end
    end
  end

  // Result monitor with random back pressure and one long hold-off.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (range_if.valid && range_ready) begin
        n_res++;
        if (range_exp_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing predicted", n_res));
        end else begin
          res_t want;
          want = range_exp_q.pop_front();
          if (range_if.pin_drive_enable !== want.pin_drive_enable)
            report_mismatch($sformatf("result %0d pin_drive_enable %b, predicted %b", n_res,
                                      range_if.pin_drive_enable, want.pin_drive_enable));
          if (range_if.pin_drive_level !== want.pin_drive_level)
            report_mismatch($sformatf("result %0d pin_drive_level %b, predicted %b", n_res,
                                      range_if.pin_drive_level, want.pin_drive_level));
          if (range_if.busy_res !== want.busy_res)
            report_mismatch($sformatf("result %0d busy_res %b, predicted %b", n_res,
                                      range_if.busy_res, want.busy_res));
          if (range_if.done_res !== want.done_res)
            report_mismatch($sformatf("result %0d done_res %b, predicted %b", n_res,
                                      range_if.done_res, want.done_res));
          if (range_if.distance_q8 !== want.distance_q8)
            report_mismatch($sformatf("result %0d distance_q8 %0d, predicted %0d", n_res,
                                      range_if.distance_q8, want.distance_q8));
          if (range_if.path_clear !== want.path_clear)
            report_mismatch($sformatf("result %0d path_clear %b, predicted %b", n_res,
                                      range_if.path_clear, want.path_clear));
        end
        range_hold = draw_gap();
        if (n_res == PRESSURE_AT) range_hold = PRESSURE_CYCLES;
      end
      if (range_hold != 0) begin
        range_ready <= 1'b0;
        range_hold--;
      end else begin
        range_ready <= 1'b1;
      end
    end
  end

  task automatic queue_tick(logic start, logic level);
    tick_q.push_back(tick_t'{start: start, level: level});
    ticks_queued++;
  endtask

  // One measurement: trigger ticks, the arming tick at lvl, n1 quiet ticks and
  // the first edge, then n2 ticks and the closing edge (elapsed is n2 + 1).
  task automatic queue_ping(int n1, int n2, logic lvl, bit pester);
    queue_tick(1'b1, 1'($urandom_range(0, 1)));
    repeat (PING_HIGH_TICKS + 1)
      queue_tick(pester | ($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)));
    repeat (n1 + 1) queue_tick(pester | ($urandom_range(0, 3) == 0), lvl);
    queue_tick(pester | ($urandom_range(0, 3) == 0), !lvl);
    repeat (n2) queue_tick(pester | ($urandom_range(0, 3) == 0), !lvl);
    queue_tick(pester | ($urandom_range(0, 3) == 0), lvl);
  endtask

  task automatic drain();
    do @(negedge clk_i); while (tick_q.size() != 0 || tick_valid || range_exp_q.size() != 0);
    @(posedge clk_i);
  endtask

  // Toggling echo ends any wait at once, so the sequencer returns to idle.
  task automatic settle_idle();
    drain();
    while (pred_phase != PH_IDLE) begin
      for (int k = 0; k < 20; k++) queue_tick(1'b0, k[0]);
      drain();
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_STOP_DISTANCE) stop_cm = value[7:0];
    else echo_limit = value;
  endtask

  initial begin
    int pings;
    int base;
    logic [15:0] limit_pick;
    logic [7:0] stop_pick;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part.
    for (int k = 0; k < 6; k++) queue_tick(1'b0, k[0]);
    queue_ping(0, 0, 1'b0, 1'b1);
    queue_ping(3, 38, 1'b1, 1'b1);
    queue_ping(0, 39, 1'b0, 1'b0);
    queue_ping(2, 40, 1'b1, 1'b0);
    settle_idle();
    write_reg(CFG_STOP_DISTANCE, 16'hA501);
    queue_ping(1, 97, 1'b0, 1'b0);
    queue_ping(1, 98, 1'b1, 1'b0);
    settle_idle();
    write_reg(CFG_STOP_DISTANCE, 16'h5AFF);
    write_reg(CFG_ECHO_TIMEOUT, 16'd50);
    queue_ping(100, 0, 1'b1, 1'b0);
    settle_idle();
    write_reg(CFG_ECHO_TIMEOUT, 16'd0);
    queue_ping(5, 5, 1'b1, 1'b0);
    settle_idle();
    write_reg(CFG_ECHO_TIMEOUT, 16'd1);
    queue_ping(0, 0, 1'b0, 1'b0);
    settle_idle();
    write_reg(CFG_ECHO_TIMEOUT, 16'hFFFF);
    queue_ping(2, 60, 1'b1, 1'b1);

    // Random part: mostly well-formed pings, some noise, across several settings.
    for (int p = 0; p < 8; p++) begin
      settle_idle();
      calm = (p % 3 == 2);
      case ($urandom_range(0, 5))
        0: stop_pick = 8'd0;
        1: stop_pick = 8'd255;
        default: stop_pick = 8'($urandom_range(0, 6));
      endcase
      case (p)
        0: limit_pick = 16'd40000;
        1: limit_pick = 16'($urandom_range(20, 400));
        2: limit_pick = 16'hFFFF;
        3: limit_pick = 16'd0;
        4: limit_pick = 16'($urandom_range(0, 65535));
        5: limit_pick = 16'd1;
        6: limit_pick = 16'($urandom_range(100, 300));
        default: limit_pick = 16'd40000;
      endcase
      write_reg(CFG_STOP_DISTANCE, {8'($urandom_range(0, 255)), stop_pick});
      write_reg(CFG_ECHO_TIMEOUT, limit_pick);
      pings = 0;
      base = ticks_queued;
      while (ticks_queued - base < 100 || pings < 2) begin
        if ($urandom_range(0, 9) < 2) begin
          repeat ($urandom_range(1, 20))
            queue_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
        end else begin
          queue_ping(($urandom_range(0, 9) == 0) ? $urandom_range(0, 100) : $urandom_range(0, 15),
                     ($urandom_range(0, 9) < 7) ? $urandom_range(0, 50) : $urandom_range(0, 150),
                     1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
          pings++;
        end
      end
    end

    do @(negedge clk_i); while (tick_q.size() != 0 || tick_valid);
    for (int k = 0; k < 5000 && range_exp_q.size() != 0; k++) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (range_exp_q.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived", range_exp_q.size()));
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
